// ----- sv/lbc_pkg.sv -----
// Package for the (16,8) linear block codec.
// Holds item structs, stage payload types, command codes and matrix helpers.
// No dependencies.
package lbc_pkg;

   localparam int CODE_ROWS = 8;
   localparam int CODE_COLS = 16;
   localparam int CSR_INDEX_W = 4;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data_in;
      logic [7:0] check_in;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [7:0] check_out;
      logic [7:0] syndrome;
      logic       error_seen;
   } rsp_type;

   typedef logic [CODE_ROWS-1:0][CODE_COLS-1:0] matrix_type;
   typedef logic [CODE_COLS-1:0][CODE_COLS-1:0] hit_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [CODE_COLS-1:0]   word;
      logic [CODE_ROWS-1:0]   syn;
   } syn_stage_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [CODE_COLS-1:0]   word;
      logic [CODE_ROWS-1:0]   syn;
      hit_type                hit;
   } match_stage_type;

   // column held at word bit b, row r at vector bit CODE_ROWS-1-r
   function automatic logic [CODE_ROWS-1:0] column_vec(input matrix_type rows,
                                                       input int b);
      logic [CODE_ROWS-1:0] v;
      v = '0;
      for (int r = 0; r < CODE_ROWS; r++) begin
         v[CODE_ROWS-1-r] = rows[r][b];
      end
      return v;
   endfunction

endpackage

// ----- sv/linear_block_16_8_codec.sv -----
// (16,8) linear block codec, top level: check-row registers and three stages.
// Throughput one item per cycle while results are taken, set by the syndrome,
// match and correction register stages.
// A stalled result back-pressures stage by stage; bubbles are filled.
// Reset (synchronous) empties all stages and clears the check rows to zero.
// Depends on lbc_pkg, lbc_syndrome, lbc_match, lbc_correct.
module linear_block_16_8_codec (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lbc_pkg::req_type                  req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lbc_pkg::rsp_type                  rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lbc_pkg::CODE_COLS-1:0]     csr_data
);
   import lbc_pkg::*;

   matrix_type      rows_ff;
   syn_stage_type   s1_item;
   match_stage_type s2_item;
   logic            s1_valid;
   logic            s1_ready;
   logic            s2_valid;
   logic            s2_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else if (csr_valid && csr_ready && (csr_index < CSR_INDEX_W'(CODE_ROWS))) begin
         rows_ff[csr_index[$clog2(CODE_ROWS)-1:0]] <= csr_data;
      end
   end

   lbc_syndrome u_syndrome (
      .clock     (clock),
      .reset     (reset),
      .rows      (rows_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item)
   );

   lbc_match u_match (
      .clock     (clock),
      .reset     (reset),
      .rows      (rows_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (s1_item),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_item  (s2_item)
   );

   lbc_correct u_correct (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_item   (s2_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

`ifndef NO_ASSERTIONS
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid && s2_valid && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while every stage is held");

   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.error_seen == (rsp_item.syndrome != '0)))
      else $error("error flag disagrees with syndrome");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !s1_valid && !s2_valid))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ----- sv/lbc_syndrome.sv -----
// First stage of the codec: builds the codeword and its row parities.
// On encode the check byte is zeroed, so the parities give the check bits.
// Depends on lbc_pkg.
module lbc_syndrome (
   input  logic                  clock,
   input  logic                  reset,
   input  lbc_pkg::matrix_type   rows,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lbc_pkg::req_type      in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output lbc_pkg::syn_stage_type out_item
);
   import lbc_pkg::*;

   logic          valid_ff;
   syn_stage_type item_ff;
   syn_stage_type item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      item_in.cmd = in_item.cmd;
      if (in_item.cmd == CMD_DECODE) begin
         item_in.word = {in_item.data_in, in_item.check_in};
      end else begin
         item_in.word = {in_item.data_in, 8'h00};
      end
      for (int r = 0; r < CODE_ROWS; r++) begin
         item_in.syn[CODE_ROWS-1-r] = ^(rows[r] & item_in.word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- sv/lbc_match.sv -----
// Second stage of the codec: compares every column and column pair
// against the syndrome, giving a symmetric hit matrix. Depends on lbc_pkg.
module lbc_match (
   input  logic                    clock,
   input  logic                    reset,
   input  lbc_pkg::matrix_type     rows,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  lbc_pkg::syn_stage_type  in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lbc_pkg::match_stage_type out_item
);
   import lbc_pkg::*;

   logic                               valid_ff;
   match_stage_type                    item_ff;
   match_stage_type                    item_in;
   logic [CODE_COLS-1:0][CODE_ROWS-1:0] col;
   logic                               active;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   assign active = (in_item.cmd == CMD_DECODE) && (in_item.syn != '0);

   always_comb begin
      for (int b = 0; b < CODE_COLS; b++) begin
         col[b] = column_vec(rows, b);
      end
      item_in.cmd  = in_item.cmd;
      item_in.word = in_item.word;
      item_in.syn  = in_item.syn;
      for (int b = 0; b < CODE_COLS; b++) begin
         for (int n = 0; n < CODE_COLS; n++) begin
            if (b == n) begin
               item_in.hit[b][n] = active && (col[b] == in_item.syn);
            end else begin
               item_in.hit[b][n] = active && ((col[b] ^ col[n]) == in_item.syn);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- sv/lbc_correct.sv -----
// Last stage of the codec: folds the hit matrix into flip bits, applies
// them and holds the result item. Depends on lbc_pkg.
module lbc_correct (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  lbc_pkg::match_stage_type in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output lbc_pkg::rsp_type         out_item
);
   import lbc_pkg::*;

   logic                 valid_ff;
   rsp_type              item_ff;
   rsp_type              item_in;
   logic [CODE_COLS-1:0] flips;
   logic [CODE_COLS-1:0] fixed;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      for (int b = 0; b < CODE_COLS; b++) begin
         flips[b] = ^in_item.hit[b];
      end
      fixed = in_item.word ^ flips;
      item_in.data_out = fixed[15:8];
      if (in_item.cmd == CMD_DECODE) begin
         item_in.check_out  = fixed[7:0];
         item_in.syndrome   = in_item.syn;
         item_in.error_seen = (in_item.syn != '0);
      end else begin
         item_in.check_out  = in_item.syn;
         item_in.syndrome   = '0;
         item_in.error_seen = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for linear_block_16_8_codec: programs the check rows,
// drives encode and decode items under random back-pressure and checks every result.
// Depends on lbc_pkg and the codec RTL.
module tb_top;
   import lbc_pkg::*;

   localparam int CODEC_LATENCY = 3;
   localparam int QUIET_LIMIT = 5000;

   class codec_scoreboard;
      logic [CODE_COLS-1:0] check_rows [CODE_ROWS];
      rsp_type owed_outputs [$];
      int failures;
      int items_seen;
      int results_seen;

      function new();
         foreach (check_rows[r]) check_rows[r] = '0;
         failures = 0;
         items_seen = 0;
         results_seen = 0;
      endfunction

      function rsp_type codec_output(input req_type it);
         rsp_type res;
         logic [CODE_COLS-1:0] word;
         logic [CODE_COLS-1:0] flips;
         logic [CODE_ROWS-1:0] syn;
         logic [CODE_ROWS-1:0] col [CODE_COLS];
         res = '0;
         if (it.cmd == CMD_ENCODE) begin
            res.data_out = it.data_in;
            for (int k = 0; k < CODE_ROWS; k++)
               res.check_out[CODE_ROWS-1-k] = ^(check_rows[k][15:8] & it.data_in);
         end else begin
            word = {it.data_in, it.check_in};
            flips = '0;
            syn = '0;
            for (int k = 0; k < CODE_ROWS; k++)
               syn[CODE_ROWS-1-k] = ^(check_rows[k] & word);
            if (syn != '0) begin
               for (int j = 0; j < CODE_COLS; j++)
                  for (int k = 0; k < CODE_ROWS; k++)
                     col[j][CODE_ROWS-1-k] = check_rows[k][CODE_COLS-1-j];
               for (int j = 0; j < CODE_COLS; j++)
                  if (col[j] == syn) flips[CODE_COLS-1-j] = ~flips[CODE_COLS-1-j];
               for (int i = 0; i < CODE_COLS - 1; i++)
                  for (int n = i + 1; n < CODE_COLS; n++)
                     if ((col[i] ^ col[n]) == syn) begin
                        flips[CODE_COLS-1-i] = ~flips[CODE_COLS-1-i];
                        flips[CODE_COLS-1-n] = ~flips[CODE_COLS-1-n];
                     end
            end
            word = word ^ flips;
            res.data_out = word[15:8];
            res.check_out = word[7:0];
            res.syndrome = syn;
            res.error_seen = (syn != '0);
         end
         return res;
      endfunction

      function void note_item(input req_type it);
         owed_outputs = {owed_outputs, codec_output(it)};
         items_seen++;
      endfunction

      function void check_item(input rsp_type got);
         rsp_type want;
         results_seen++;
         if (owed_outputs.size() == 0) begin
            $error("result arrived with nothing pending: %h", got);
            failures++;
         end else begin
            want = owed_outputs.pop_front();
            if (got.data_out !== want.data_out) begin
               $error("data_out expected %h actual %h", want.data_out, got.data_out);
               failures++;
            end
            if (got.check_out !== want.check_out) begin
               $error("check_out expected %h actual %h", want.check_out, got.check_out);
               failures++;
            end
            if (got.syndrome !== want.syndrome) begin
               $error("syndrome expected %h actual %h", want.syndrome, got.syndrome);
               failures++;
            end
            if (got.error_seen !== want.error_seen) begin
               $error("error_seen expected %b actual %b", want.error_seen, got.error_seen);
               failures++;
            end
         end
      endfunction

      function int owed_count();
         return owed_outputs.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CODE_COLS-1:0] csr_data = '0;

   bit calm = 1'b0;
   int settings_run = 0;
   codec_scoreboard sb = new();

   linear_block_16_8_codec uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_item(req_item);
         if (rsp_valid && rsp_ready) sb.check_item(rsp_item);
      end
   end

   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_ready <= 1'b1;
            hold = 0;
         end else if (hold == 0) begin
            if ($urandom_range(0, 2) == 0) begin
               rsp_ready <= 1'b0;
               hold = $urandom_range(0, 16);
            end else begin
               rsp_ready <= 1'b1;
               hold = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
            end
         end else begin
            hold--;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic write_row(input logic [CSR_INDEX_W-1:0] idx, input logic [CODE_COLS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < CODE_ROWS) sb.check_rows[idx[$clog2(CODE_ROWS)-1:0]] = val;
   endtask

   task automatic load_matrix(input matrix_type m, input bit junk);
      for (int r = 0; r < CODE_ROWS; r++) begin
         write_row(r[CSR_INDEX_W-1:0], m[r]);
         if (junk && $urandom_range(0, 1) == 0)
            write_row(CSR_INDEX_W'(CODE_ROWS + $urandom_range(0, CODE_ROWS - 1)),
                      CODE_COLS'($urandom));
      end
      csr_valid <= 1'b0;
      settings_run++;
   endtask

   task automatic send_item(input req_type it);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_encode(input logic [7:0] d, input logic [7:0] c);
      req_type it;
      it.cmd = CMD_ENCODE;
      it.data_in = d;
      it.check_in = c;
      send_item(it);
   endtask

   task automatic send_decode(input logic [CODE_COLS-1:0] w);
      req_type it;
      it.cmd = CMD_DECODE;
      it.data_in = w[15:8];
      it.check_in = w[7:0];
      send_item(it);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sb.owed_count() != 0) @(posedge clock);
      repeat (CODEC_LATENCY + 1) @(posedge clock);
   endtask

   function automatic logic [CODE_COLS-1:0] codeword(input logic [7:0] d);
      req_type it;
      rsp_type res;
      it.cmd = CMD_ENCODE;
      it.data_in = d;
      it.check_in = '0;
      res = sb.codec_output(it);
      return {d, res.check_out};
   endfunction

   function automatic req_type random_item();
      req_type it;
      logic [CODE_COLS-1:0] w;
      int unsigned pick;
      pick = $urandom_range(0, 7);
      it.data_in = 8'($urandom);
      it.check_in = 8'($urandom);
      if (pick < 2) begin
         it.cmd = CMD_ENCODE;
      end else begin
         it.cmd = CMD_DECODE;
         if (pick < 7) begin
            w = codeword(it.data_in);
            repeat ($urandom_range(0, 3))
               w[$clog2(CODE_COLS)'($urandom_range(0, CODE_COLS - 1))] ^= 1'b1;
            it.data_in = w[15:8];
            it.check_in = w[7:0];
         end
      end
      return it;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_item(random_item());
      drain();
   endtask

   function automatic matrix_type random_matrix(input int shape);
      matrix_type m;
      for (int r = 0; r < CODE_ROWS; r++) begin
         case (shape)
            0: m[r] = 16'($urandom);
            1: m[r] = {8'($urandom), 8'h80 >> r};
            default: begin
               if (r > 0 && $urandom_range(0, 2) == 0) m[r] = m[r-1];
               else m[r] = 16'h0001 << $urandom_range(0, CODE_COLS - 1);
            end
         endcase
      end
      return m;
   endfunction

   initial begin
      matrix_type m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_random(20);

      m = {16'hD880, 16'hB440, 16'h6E20, 16'h1B10, 16'h8D08, 16'hC604, 16'h6302, 16'h3101};
      write_row(CSR_INDEX_W'(CODE_ROWS), 16'hFFFF);
      write_row({CSR_INDEX_W{1'b1}}, 16'hFFFF);
      load_matrix(m, 1'b0);
      send_encode(8'h00, 8'hFF);
      send_encode(8'hFF, 8'h00);
      send_encode(8'h80, 8'hA5);
      send_encode(8'h01, 8'h5A);
      send_decode(codeword(8'hC3));
      send_decode(16'h0000);
      send_decode(16'hFFFF);
      send_decode(codeword(8'h5A) ^ 16'h8000);
      send_decode(codeword(8'h5A) ^ 16'h0100);
      send_decode(codeword(8'h5A) ^ 16'h0080);
      send_decode(codeword(8'h5A) ^ 16'h0001);
      send_decode(codeword(8'h3C) ^ 16'h8001);
      send_decode(codeword(8'h3C) ^ 16'h0180);
      send_decode(codeword(8'hFF) ^ 16'h0007);
      drain();

      m = {CODE_ROWS{16'hFFFF}};
      load_matrix(m, 1'b0);
      send_decode(16'h8000);
      send_decode(16'h0001);
      send_decode(16'hFFFF);
      send_encode(8'hFF, 8'hFF);
      send_encode(8'h7F, 8'h00);
      run_random(100);

      load_matrix(random_matrix(0), 1'b1);
      run_random(140);
      load_matrix(random_matrix(1), 1'b1);
      run_random(140);
      load_matrix(random_matrix(2), 1'b0);
      run_random(140);
      load_matrix(random_matrix(0), 1'b1);
      run_random(140);

      m = '0;
      load_matrix(m, 1'b1);
      run_random(40);

      calm = 1'b1;
      load_matrix(random_matrix(1), 1'b0);
      run_random(140);

      $display("Covered %0d items and %0d results over %0d check-matrix settings,",
               sb.items_seen, sb.results_seen, settings_run);
      $display("including zero, all-ones, systematic, sparse and ignored row writes.");
      if (sb.failures == 0 && sb.owed_count() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
